>>> rtl/core/psar_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psar_pkg
// Shared types and constants for the scroll / video-address register unit.
// ----------------------------------------------------------------------------
package psar_pkg;

   localparam int unsigned AddrWidth   = 15;
   localparam int unsigned FetchWidth  = 14;
   localparam int unsigned ActionWidth = 4;
   localparam int unsigned DataWidth   = 8;
   localparam int unsigned FineWidth   = 3;
   localparam int unsigned ShiftWidth  = 3;

   localparam logic [4:0] CoarseYWrapRow = 5'd29;
   localparam logic [4:0] CoarseMax      = 5'd31;
   localparam logic [2:0] FineYMax       = 3'd7;

   typedef enum logic [ActionWidth-1:0] {
      ACT_CTRL_WRITE   = 4'd0,
      ACT_MASK_WRITE   = 4'd1,
      ACT_STATUS_READ  = 4'd2,
      ACT_SCROLL_WRITE = 4'd3,
      ACT_ADDR_WRITE   = 4'd4,
      ACT_DATA_ACCESS  = 4'd5,
      ACT_INC_X        = 4'd6,
      ACT_INC_Y        = 4'd7,
      ACT_COPY_X       = 4'd8,
      ACT_COPY_Y       = 4'd9
   } action_type;

   typedef struct packed {
      logic [AddrWidth-1:0] current_addr;
      logic [AddrWidth-1:0] pending_addr;
      logic [FineWidth-1:0] fine_scroll;
      logic                 second_write;
      logic                 row_increment;
      logic                 render_enable;
   } state_type;

   typedef struct packed {
      logic [FetchWidth-1:0] tile_fetch_address;
      logic [FetchWidth-1:0] attribute_fetch_address;
      logic [ShiftWidth-1:0] attribute_shift;
   } fetch_type;

endpackage
`default_nettype wire

>>> rtl/core/psar_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psar_step
// Next-state logic: apply one action word to the scroll/address registers.
// ----------------------------------------------------------------------------
module psar_step (
   input  wire psar_pkg::state_type                  state_cur,
   input  wire logic [psar_pkg::ActionWidth-1:0]     action,
   input  wire logic [psar_pkg::DataWidth-1:0]       data_byte,
   output psar_pkg::state_type                       state_nxt
);
   import psar_pkg::*;

   logic [AddrWidth-1:0] v;
   logic [AddrWidth-1:0] t;
   logic [AddrWidth-1:0] inc_x_addr;
   logic [AddrWidth-1:0] inc_y_addr;
   logic [AddrWidth-1:0] step_addr;
   logic [4:0]           cx;
   logic [4:0]           cy;
   logic [2:0]           fy;
   logic [4:0]           cy_nxt;
   logic                 nt_y_flip;

   assign v  = state_cur.current_addr;
   assign t  = state_cur.pending_addr;
   assign cx = v[4:0];
   assign cy = v[9:5];
   assign fy = v[14:12];

   // Coarse X: wrap at 31 and flip horizontal nametable.
   always_comb begin
      inc_x_addr = v;
      if (cx == CoarseMax) begin
         inc_x_addr[4:0] = 5'd0;
         inc_x_addr[10]  = ~v[10];
      end else begin
         inc_x_addr[4:0] = cx + 5'd1;
      end
   end

   // Fine Y, then coarse Y with the row-29 wrap.
   always_comb begin
      nt_y_flip = 1'b0;
      cy_nxt    = cy + 5'd1;
      if (cy == CoarseYWrapRow) begin
         cy_nxt    = 5'd0;
         nt_y_flip = 1'b1;
      end else if (cy == CoarseMax) begin
         cy_nxt = 5'd0;
      end
      inc_y_addr = v;
      if (fy != FineYMax) begin
         inc_y_addr[14:12] = fy + 3'd1;
      end else begin
         inc_y_addr[14:12] = 3'd0;
         inc_y_addr[9:5]   = cy_nxt;
         inc_y_addr[11]    = v[11] ^ nt_y_flip;
      end
   end

   assign step_addr = v + (state_cur.row_increment ? AddrWidth'(32) : AddrWidth'(1));

   always_comb begin
      state_nxt = state_cur;
      unique case (action_type'(action))
         ACT_CTRL_WRITE: begin
            state_nxt.pending_addr[11:10] = data_byte[1:0];
            state_nxt.row_increment       = data_byte[2];
         end
         ACT_MASK_WRITE: begin
            state_nxt.render_enable = |data_byte[4:3];
         end
         ACT_STATUS_READ: begin
            state_nxt.second_write = 1'b0;
         end
         ACT_SCROLL_WRITE: begin
            if (!state_cur.second_write) begin
               state_nxt.fine_scroll       = data_byte[2:0];
               state_nxt.pending_addr[4:0] = data_byte[7:3];
               state_nxt.second_write      = 1'b1;
            end else begin
               state_nxt.pending_addr[14:12] = data_byte[2:0];
               state_nxt.pending_addr[9:5]   = data_byte[7:3];
               state_nxt.second_write        = 1'b0;
            end
         end
         ACT_ADDR_WRITE: begin
            if (!state_cur.second_write) begin
               state_nxt.pending_addr = {1'b0, data_byte[5:0], t[7:0]};
               state_nxt.second_write = 1'b1;
            end else begin
               state_nxt.pending_addr = {t[14:8], data_byte};
               state_nxt.current_addr = {t[14:8], data_byte};
               state_nxt.second_write = 1'b0;
            end
         end
         ACT_DATA_ACCESS: begin
            state_nxt.current_addr = step_addr;
         end
         ACT_INC_X: begin
            if (state_cur.render_enable) state_nxt.current_addr = inc_x_addr;
         end
         ACT_INC_Y: begin
            if (state_cur.render_enable) state_nxt.current_addr = inc_y_addr;
         end
         ACT_COPY_X: begin
            if (state_cur.render_enable) begin
               state_nxt.current_addr[4:0] = t[4:0];
               state_nxt.current_addr[10]  = t[10];
            end
         end
         ACT_COPY_Y: begin
            if (state_cur.render_enable) begin
               state_nxt.current_addr[9:5]   = t[9:5];
               state_nxt.current_addr[14:11] = t[14:11];
            end
         end
         default: begin
            state_nxt = state_cur;
         end
      endcase
   end

endmodule
`default_nettype wire

>>> rtl/core/psar_fetch.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psar_fetch
// Derive tile and attribute fetch addresses from the current address.
// ----------------------------------------------------------------------------
module psar_fetch (
   input  wire logic [psar_pkg::AddrWidth-1:0] current_addr,
   output psar_pkg::fetch_type                 fetch
);
   import psar_pkg::*;

   logic [4:0] cx;
   logic [4:0] cy;

   assign cx = current_addr[4:0];
   assign cy = current_addr[9:5];

   // Tile: 0x2000 | v[11:0]. Attribute: 0x23C0 | nt | cy[4:2] << 3 | cx[4:2].
   assign fetch.tile_fetch_address      = {2'b10, current_addr[11:0]};
   assign fetch.attribute_fetch_address = {2'b10, current_addr[11:10], 4'b1111,
                                           cy[4:2], cx[4:2]};
   assign fetch.attribute_shift         = {cy[1], cx[1], 1'b0};

endmodule
`default_nettype wire

>>> rtl/core/ppu_scroll_address_registers.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppu_scroll_address_registers
// Scroll and video-address register unit (v/t/x/w scheme) of a tile engine.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): one word per action, a CPU register write,
//   status read, data-port access or render tick, with its data byte.
//   Response channel (rsp_*): one word per request, showing the registers
//   after the action plus the tile/attribute fetch addresses and the
//   attribute shift taken from the updated current address.
//   Response: registered; it is valid in the cycle after the request is taken.
//   Throughput: one request per cycle while responses are taken; the register
//   update and the fetch address logic both sit in one combinational pass
//   ahead of the response register.
//   Stall: the response register holds while rsp_ready is low; req_ready
//   drops only while a response is held, and rises again in the cycle the
//   held word is taken, so a new request can enter in that same cycle.
//   Reset: all scroll/address state clears to zero (step by one, rendering
//   off, toggle cleared) and the response register empties.
//   Render ticks change nothing while both mask bits 3 and 4 are clear.
// ----------------------------------------------------------------------------
module ppu_scroll_address_registers (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [psar_pkg::ActionWidth-1:0]    req_action,
   input  wire logic [psar_pkg::DataWidth-1:0]      req_data_byte,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [psar_pkg::AddrWidth-1:0]           rsp_vram_address,
   output logic [psar_pkg::AddrWidth-1:0]           rsp_temp_address,
   output logic [psar_pkg::FineWidth-1:0]           rsp_fine_x_scroll,
   output logic                                     rsp_write_toggle,
   output logic [psar_pkg::FetchWidth-1:0]          rsp_tile_fetch_address,
   output logic [psar_pkg::FetchWidth-1:0]          rsp_attribute_fetch_address,
   output logic [psar_pkg::ShiftWidth-1:0]          rsp_attribute_shift
);
   import psar_pkg::*;

   state_type state_ff;
   state_type state_in;
   fetch_type fetch_in;
   state_type rsp_state_ff;
   fetch_type rsp_fetch_ff;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      req_take;

   // Take a new word whenever the response slot is empty or being drained.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;

   psar_step u_psar_step (
      .state_cur (state_ff),
      .action    (req_action),
      .data_byte (req_data_byte),
      .state_nxt (state_in)
   );

   psar_fetch u_psar_fetch (
      .current_addr (state_in.current_addr),
      .fetch        (fetch_in)
   );

   // Architectural state: advance only on an accepted word.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (req_take) begin
         state_ff <= state_in;
      end
   end

   // Response valid: set on accept, drop once taken with nothing new behind it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload: load on accept, hold otherwise.
   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_state_ff <= state_in;
         rsp_fetch_ff <= fetch_in;
      end
   end

   assign rsp_valid                   = rsp_valid_ff;
   assign rsp_vram_address            = rsp_state_ff.current_addr;
   assign rsp_temp_address            = rsp_state_ff.pending_addr;
   assign rsp_fine_x_scroll           = rsp_state_ff.fine_scroll;
   assign rsp_write_toggle            = rsp_state_ff.second_write;
   assign rsp_tile_fetch_address      = rsp_fetch_ff.tile_fetch_address;
   assign rsp_attribute_fetch_address = rsp_fetch_ff.attribute_fetch_address;
   assign rsp_attribute_shift         = rsp_fetch_ff.attribute_shift;

endmodule
`default_nettype wire

>>> rtl/core/psar_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psar_checker
// Port-level checks for the scroll/address register unit, bound to the top.
// ----------------------------------------------------------------------------
module psar_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_ready,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_ready,
   input wire logic [psar_pkg::AddrWidth-1:0]      rsp_vram_address,
   input wire logic [psar_pkg::AddrWidth-1:0]      rsp_temp_address,
   input wire logic [psar_pkg::FineWidth-1:0]      rsp_fine_x_scroll,
   input wire logic                                rsp_write_toggle,
   input wire logic [psar_pkg::FetchWidth-1:0]     rsp_tile_fetch_address,
   input wire logic [psar_pkg::FetchWidth-1:0]     rsp_attribute_fetch_address,
   input wire logic [psar_pkg::ShiftWidth-1:0]     rsp_attribute_shift
);
   import psar_pkg::*;

   // An accepted word shows up as a response in the next cycle.
   a_accept_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted word did not produce a response");

   // Never stall the request side while the response slot is free.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req_ready low with empty response slot");

   // A held response keeps its word.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_vram_address)
         && $stable(rsp_temp_address) && $stable(rsp_write_toggle)
         && $stable(rsp_fine_x_scroll) && $stable(rsp_tile_fetch_address)
         && $stable(rsp_attribute_fetch_address) && $stable(rsp_attribute_shift))
      else $error("stalled response changed");

   // Fetch outputs follow the reported current address.
   a_fetch_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_tile_fetch_address[11:0] == rsp_vram_address[11:0]
         && rsp_attribute_fetch_address[11:10] == rsp_vram_address[11:10]
         && rsp_attribute_fetch_address[2:0] == rsp_vram_address[4:2]
         && rsp_attribute_shift[2] == rsp_vram_address[6]
         && rsp_attribute_shift[1] == rsp_vram_address[1])
      else $error("fetch address does not match current address");

   // Response slot is empty right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind ppu_scroll_address_registers psar_checker u_psar_checker (.*);
`default_nettype wire

>>> tb/tb_ppu_scroll_address_registers.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ppu_scroll_address_registers
// Self-checking bench for the scroll / video-address register unit. A local
// shadow of the v/t/x/w registers predicts every response word. Directed
// tests cover the register writes, the render ticks and the address port.
// A random phase then runs scroll setups, address setups and long runs of
// render ticks. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_ppu_scroll_address_registers;
   import psar_pkg::*;

   localparam logic [FetchWidth-1:0] TileBase = 14'h2000;
   localparam logic [FetchWidth-1:0] AttrBase = 14'h23C0;
   localparam logic [ActionWidth-1:0] ActUnused = 4'hF;
   localparam int RandomWords = 360;

   typedef struct packed {
      logic [AddrWidth-1:0]  vram_address;
      logic [AddrWidth-1:0]  temp_address;
      logic [FineWidth-1:0]  fine_x_scroll;
      logic                  write_toggle;
      logic [FetchWidth-1:0] tile_fetch_address;
      logic [FetchWidth-1:0] attribute_fetch_address;
      logic [ShiftWidth-1:0] attribute_shift;
   } reg_view_t;

   // Drive every input to a known value from time zero.
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic [ActionWidth-1:0] req_action = '0;
   logic [DataWidth-1:0]   req_data_byte = '0;
   logic                   rsp_ready = 1'b0;

   logic                   req_ready;
   logic                   rsp_valid;
   logic [AddrWidth-1:0]   rsp_vram_address;
   logic [AddrWidth-1:0]   rsp_temp_address;
   logic [FineWidth-1:0]   rsp_fine_x_scroll;
   logic                   rsp_write_toggle;
   logic [FetchWidth-1:0]  rsp_tile_fetch_address;
   logic [FetchWidth-1:0]  rsp_attribute_fetch_address;
   logic [ShiftWidth-1:0]  rsp_attribute_shift;

   // Shadow copy of the register state; it starts out as reset leaves it.
   logic [AddrWidth-1:0]   shadow_vram = '0;
   logic [AddrWidth-1:0]   shadow_temp = '0;
   logic [FineWidth-1:0]   shadow_fine_x = '0;
   logic                   shadow_toggle = 1'b0;
   logic                   shadow_step32 = 1'b0;
   logic                   shadow_render = 1'b0;

   reg_view_t views_due[$];
   int        mismatches = 0;
   int        words_sent = 0;
   bit        idle_on = 1'b1;
   // Handshake flags, sampled at the falling edge ahead of the rising edge
   // that completes the handshake.
   bit        req_fire = 1'b0;
   bit        rsp_fire = 1'b0;

   ppu_scroll_address_registers dut (
      .clock                       (clock),
      .reset                       (reset),
      .req_valid                   (req_valid),
      .req_ready                   (req_ready),
      .req_action                  (req_action),
      .req_data_byte               (req_data_byte),
      .rsp_valid                   (rsp_valid),
      .rsp_ready                   (rsp_ready),
      .rsp_vram_address            (rsp_vram_address),
      .rsp_temp_address            (rsp_temp_address),
      .rsp_fine_x_scroll           (rsp_fine_x_scroll),
      .rsp_write_toggle            (rsp_write_toggle),
      .rsp_tile_fetch_address      (rsp_tile_fetch_address),
      .rsp_attribute_fetch_address (rsp_attribute_fetch_address),
      .rsp_attribute_shift         (rsp_attribute_shift)
   );

   always #5 clock = ~clock;

   // Apply one action to the shadow registers and return the word the block
   // must answer with.
   function automatic reg_view_t advance_scroll_regs(input logic [ActionWidth-1:0] act,
                                                     input logic [DataWidth-1:0] byte_in);
      reg_view_t  view;
      logic [4:0] tile_col;
      logic [4:0] tile_row;
      case (act)
         ACT_CTRL_WRITE: begin
            // Keep only the nametable select and the increment size.
            shadow_temp[11:10] = byte_in[1:0];
            shadow_step32      = byte_in[2];
         end
         ACT_MASK_WRITE: begin
            shadow_render = byte_in[3] | byte_in[4];
         end
         ACT_STATUS_READ: begin
            shadow_toggle = 1'b0;
         end
         ACT_SCROLL_WRITE: begin
            if (!shadow_toggle) begin
               shadow_fine_x    = byte_in[2:0];
               shadow_temp[4:0] = byte_in[7:3];
            end else begin
               shadow_temp[14:12] = byte_in[2:0];
               shadow_temp[9:5]   = byte_in[7:3];
            end
            shadow_toggle = ~shadow_toggle;
         end
         ACT_ADDR_WRITE: begin
            // The high byte clears bit 14. The low byte loads v from t.
            if (!shadow_toggle) begin
               shadow_temp[14]   = 1'b0;
               shadow_temp[13:8] = byte_in[5:0];
            end else begin
               shadow_temp[7:0] = byte_in;
               shadow_vram      = shadow_temp;
            end
            shadow_toggle = ~shadow_toggle;
         end
         ACT_DATA_ACCESS: begin
            // The sum wraps within the 15-bit address.
            shadow_vram = shadow_vram + (shadow_step32 ? 15'd32 : 15'd1);
         end
         ACT_INC_X: begin
            if (shadow_render) begin
               if (shadow_vram[4:0] == CoarseMax) begin
                  shadow_vram[4:0] = '0;
                  shadow_vram[10]  = ~shadow_vram[10];
               end else begin
                  shadow_vram[4:0] = shadow_vram[4:0] + 5'd1;
               end
            end
         end
         ACT_INC_Y: begin
            if (shadow_render) begin
               if (shadow_vram[14:12] != FineYMax) begin
                  shadow_vram[14:12] = shadow_vram[14:12] + 3'd1;
               end else begin
                  shadow_vram[14:12] = '0;
                  // Row 29 wraps and flips the nametable. Row 31 wraps
                  // without the flip.
                  if (shadow_vram[9:5] == CoarseYWrapRow) begin
                     shadow_vram[9:5] = '0;
                     shadow_vram[11]  = ~shadow_vram[11];
                  end else if (shadow_vram[9:5] == CoarseMax) begin
                     shadow_vram[9:5] = '0;
                  end else begin
                     shadow_vram[9:5] = shadow_vram[9:5] + 5'd1;
                  end
               end
            end
         end
         ACT_COPY_X: begin
            if (shadow_render) begin
               shadow_vram[4:0] = shadow_temp[4:0];
               shadow_vram[10]  = shadow_temp[10];
            end
         end
         ACT_COPY_Y: begin
            if (shadow_render) begin
               shadow_vram[14:11] = shadow_temp[14:11];
               shadow_vram[9:5]   = shadow_temp[9:5];
            end
         end
         default: begin
         end
      endcase
      tile_col = shadow_vram[4:0];
      tile_row = shadow_vram[9:5];
      view.vram_address            = shadow_vram;
      view.temp_address            = shadow_temp;
      view.fine_x_scroll           = shadow_fine_x;
      view.write_toggle            = shadow_toggle;
      view.tile_fetch_address      = TileBase | {2'b00, shadow_vram[11:0]};
      view.attribute_fetch_address = AttrBase | {2'b00, shadow_vram[11:10], 10'd0}
                                     | {8'd0, tile_row[4:2], 3'd0}
                                     | {11'd0, tile_col[4:2]};
      view.attribute_shift         = {tile_row[1], tile_col[1], 1'b0};
      return view;
   endfunction

   function automatic int draw_gap();
      return idle_on ? $urandom_range(0, 9) : 0;
   endfunction

   task automatic compare_field(input string field, input logic [15:0] want,
                                input logic [15:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
         mismatches++;
      end
   endtask

   // Find the handshakes at the falling edge. Predict on request words and
   // check response words against the oldest prediction.
   always @(negedge clock) begin
      reg_view_t want;
      req_fire = !reset && req_valid && req_ready;
      rsp_fire = !reset && rsp_valid && rsp_ready;
      if (req_fire) begin
         views_due.push_back(advance_scroll_regs(req_action, req_data_byte));
      end
      if (rsp_fire) begin
         if (views_due.size() == 0) begin
            $display("%0t ns: response word with nothing outstanding, actual vram %h",
                     $time, rsp_vram_address);
            mismatches++;
         end else begin
            want = views_due.pop_front();
            compare_field("vram_address", 16'(want.vram_address),
                          16'(rsp_vram_address));
            compare_field("temp_address", 16'(want.temp_address),
                          16'(rsp_temp_address));
            compare_field("fine_x_scroll", 16'(want.fine_x_scroll),
                          16'(rsp_fine_x_scroll));
            compare_field("write_toggle", 16'(want.write_toggle),
                          16'(rsp_write_toggle));
            compare_field("tile_fetch_address", 16'(want.tile_fetch_address),
                          16'(rsp_tile_fetch_address));
            compare_field("attribute_fetch_address", 16'(want.attribute_fetch_address),
                          16'(rsp_attribute_fetch_address));
            compare_field("attribute_shift", 16'(want.attribute_shift),
                          16'(rsp_attribute_shift));
         end
      end
   end

   // Stall the response side at random. Then hold ready high until one word
   // has been taken.
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = draw_gap();
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_fire);
      end
   end

   // Send one request word. Valid stays high on return, so a follow-on word
   // with no gap goes out in the next cycle without a drop in valid.
   task automatic send_word(input logic [ActionWidth-1:0] act,
                            input logic [DataWidth-1:0] byte_in);
      int gap;
      gap = draw_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_action    <= act;
      req_data_byte <= byte_in;
      do @(posedge clock); while (!req_fire);
      words_sent++;
   endtask

   // Drop valid and hold off until every outstanding response has arrived.
   task automatic pause_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (views_due.size() != 0);
   endtask

   // Cover the toggle on both halves of the scroll write and the status
   // read that clears it. This leaves t at all ones.
   task automatic test_cpu_register_writes();
      send_word(ACT_CTRL_WRITE, 8'hFF);
      send_word(ACT_SCROLL_WRITE, 8'hFF);
      send_word(ACT_STATUS_READ, 8'h00);
      send_word(ACT_SCROLL_WRITE, 8'hFF);
      send_word(ACT_SCROLL_WRITE, 8'hFF);
   endtask

   // Cover the render ticks: enabled through either mask bit, blocked while
   // both are clear, and the coarse X and row wraps.
   task automatic test_render_ticks();
      send_word(ACT_MASK_WRITE, 8'h08);
      send_word(ACT_COPY_X, 8'h00);
      send_word(ACT_COPY_Y, 8'h00);
      // v is all ones, so this step by 32 wraps past the top.
      send_word(ACT_DATA_ACCESS, 8'h00);
      send_word(ACT_CTRL_WRITE, 8'h00);
      // Coarse X is 31, so the increment flips the horizontal nametable.
      send_word(ACT_INC_X, 8'h00);
      send_word(ACT_COPY_Y, 8'h00);
      // Fine Y 7 on row 31 wraps the row without flipping the nametable.
      send_word(ACT_INC_Y, 8'h00);
      send_word(ACT_SCROLL_WRITE, 8'h00);
      send_word(ACT_SCROLL_WRITE, 8'hEF);
      send_word(ACT_COPY_Y, 8'h00);
      // Row 29 wraps and flips the vertical nametable.
      send_word(ACT_INC_Y, 8'h00);
      send_word(ACT_MASK_WRITE, 8'h10);
      send_word(ACT_SCROLL_WRITE, 8'h00);
      send_word(ACT_SCROLL_WRITE, 8'hF7);
      send_word(ACT_COPY_Y, 8'h00);
      // Row 30 just counts up to 31.
      send_word(ACT_INC_Y, 8'h00);
      // Every mask bit except 3 and 4: rendering turns off.
      send_word(ACT_MASK_WRITE, 8'hE7);
      send_word(ACT_INC_Y, 8'h00);
   endtask

   // The high byte drops bit 14. The data port then steps by one.
   task automatic test_address_port();
      send_word(ACT_ADDR_WRITE, 8'hFF);
      send_word(ACT_ADDR_WRITE, 8'hFF);
      send_word(ACT_DATA_ACCESS, 8'h00);
   endtask

   task automatic test_unused_actions();
      send_word(ActUnused, 8'hA5);
   endtask

   // Run a short burst. Then hold off until every response is in, and
   // run another burst.
   task automatic test_drain_pause();
      send_word(ACT_DATA_ACCESS, 8'($urandom));
      send_word(ACT_SCROLL_WRITE, 8'($urandom));
      pause_until_drained();
      send_word(ACT_STATUS_READ, 8'($urandom));
      send_word(ACT_DATA_ACCESS, 8'($urandom));
   endtask

   // Run mostly well-formed sequences: scroll setups, address setups with
   // data-port traffic, and render lines of copies and increments. Mix in
   // lone random words, unused codes among them.
   task automatic test_random_traffic();
      int            stop_at;
      int            pick;
      int            count;
      logic [7:0]    mask_byte;
      stop_at = words_sent + RandomWords;
      while (words_sent < stop_at) begin
         // Leave the occasional stretch with no idling on either side.
         idle_on = ($urandom_range(0, 4) != 0);
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            pause_until_drained();
         end else if (pick <= 5) begin
            send_word(4'($urandom_range(0, 15)), 8'($urandom));
         end else if (pick <= 8) begin
            if ($urandom_range(0, 1)) send_word(ACT_STATUS_READ, 8'($urandom));
            send_word(ACT_SCROLL_WRITE, 8'($urandom));
            send_word(ACT_SCROLL_WRITE, 8'($urandom));
         end else if (pick <= 11) begin
            if ($urandom_range(0, 1)) send_word(ACT_STATUS_READ, 8'($urandom));
            if ($urandom_range(0, 2) == 0) send_word(ACT_CTRL_WRITE, 8'($urandom));
            send_word(ACT_ADDR_WRITE, 8'($urandom));
            send_word(ACT_ADDR_WRITE, 8'($urandom));
            count = $urandom_range(0, 4);
            repeat (count) send_word(ACT_DATA_ACCESS, 8'($urandom));
         end else begin
            // Keep rendering on most of the time.
            mask_byte = 8'($urandom);
            if ($urandom_range(0, 3) != 0) mask_byte[3] = 1'b1;
            send_word(ACT_MASK_WRITE, mask_byte);
            send_word(ACT_COPY_X, 8'($urandom));
            send_word(ACT_COPY_Y, 8'($urandom));
            count = $urandom_range(8, 40);
            repeat (count) begin
               case ($urandom_range(0, 5))
                  0, 1, 2: send_word(ACT_INC_X, 8'($urandom));
                  3, 4:    send_word(ACT_INC_Y, 8'($urandom));
                  default: send_word(ACT_COPY_X, 8'($urandom));
               endcase
            end
         end
      end
      idle_on = 1'b1;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_cpu_register_writes();
      test_render_ticks();
      test_address_port();
      test_unused_actions();
      test_drain_pause();
      test_random_traffic();
      pause_until_drained();
      // Leave room for any stray response after the last expected one.
      repeat (4) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_ppu_scroll_address_registers OK");
      end else begin
         $display("tb_ppu_scroll_address_registers NOT OK");
      end
      $finish;
   end

   // Stop the run if the handshakes hang.
   initial begin
      #2_000_000;
      $display("%0t ns: timeout, %0d responses outstanding", $time, views_due.size());
      $display("tb_ppu_scroll_address_registers NOT OK");
      $finish;
   end

endmodule
